// File: design/isaf_pkg.sv
// Shared types and constants of the IPv4 source address filter.
package isaf_pkg;

  localparam int unsigned ETH_HDR_LEN = 14;
  localparam int unsigned IP_END_LEN = 34;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] MATCH_FLAG = 8'd1;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    RSN_SHORT_MAC = 3'd0,
    RSN_NOT_IPV4  = 3'd1,
    RSN_SHORT_IP  = 3'd2,
    RSN_DENIED    = 3'd3,
    RSN_ALLOWED   = 3'd4,
    RSN_DEFAULT   = 3'd5
  } reason_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_SET,
    OP_REMOVE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MV_RD,
    ST_MV_WR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  flag;
  } entry_t;

  // Header parser report for the beat just accepted.
  typedef struct packed {
    logic        done;
    logic        lookup;
    reason_e     reason;
    logic [31:0] src;
  } frm_t;

  typedef struct packed {
    kind_e       kind;
    logic        drop;
    reason_e     reason;
    status_e     status;
    logic [31:0] src;
  } res_t;

endpackage

// File: design/isaf_in_if.sv
// Input channel of the filter: frame bytes and table operations.
interface isaf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        list_select;
  logic [31:0] address_key;
  logic [7:0]  flag_value;

  modport source(output valid, action, data_byte, last_byte, list_select, address_key,
                 flag_value, input ready);
  modport sink(input valid, action, data_byte, last_byte, list_select, address_key,
               flag_value, output ready);
endinterface

// File: design/isaf_out_if.sv
// Output channel of the filter: verdicts and table operation status.
interface isaf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        drop_frame;
  logic [2:0]  verdict_reason;
  logic [1:0]  op_status;
  logic [31:0] source_address;

  modport source(output valid, result_kind, drop_frame, verdict_reason, op_status,
                 source_address, input ready);
  modport sink(input valid, result_kind, drop_frame, verdict_reason, op_status,
               source_address, output ready);
endinterface

// File: design/isaf_ram.sv
// Generic single-port-write, registered-read RAM.
module isaf_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/isaf_hdr.sv
// Frame header tracker: byte position, EtherType and source address capture.
module isaf_hdr import isaf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output frm_t       frm_o
);

  logic [5:0]  pos_q, pos_d, pos_nx;
  logic [15:0] etype_q, etype_d, etype_nx;
  logic [31:0] src_q, src_d, src_nx;

  always_comb begin
    etype_nx = etype_q;
    src_nx   = src_q;
    pos_nx   = pos_q;
    if (pos_q == 6'd12 || pos_q == 6'd13) begin
      etype_nx = {etype_q[7:0], data_i};
    end
    if (pos_q >= 6'd26 && pos_q <= 6'd29) begin
      src_nx = {src_q[23:0], data_i};
    end
    if (pos_q < 6'(IP_END_LEN)) begin
      pos_nx = pos_q + 6'd1;
    end
  end

  always_comb begin
    frm_o.done   = en_i && last_i;
    frm_o.lookup = 1'b0;
    frm_o.src    = '0;
    if (pos_nx < 6'(ETH_HDR_LEN)) begin
      frm_o.reason = RSN_SHORT_MAC;
    end else if (etype_nx != ETHERTYPE_IPV4) begin
      frm_o.reason = RSN_NOT_IPV4;
    end else if (pos_nx < 6'(IP_END_LEN)) begin
      frm_o.reason = RSN_SHORT_IP;
    end else begin
      frm_o.reason = RSN_DEFAULT;
      frm_o.lookup = 1'b1;
      frm_o.src    = src_nx;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    etype_d = etype_q;
    src_d   = src_q;
    if (en_i) begin
      if (last_i) begin
        pos_d   = '0;
        etype_d = '0;
        src_d   = '0;
      end else begin
        pos_d   = pos_nx;
        etype_d = etype_nx;
        src_d   = src_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      etype_q <= '0;
      src_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      etype_q <= etype_d;
      src_q   <= src_d;
    end
  end

endmodule

// File: design/ipv4_source_acl_filter_unit.sv
// Frame filter on IPv4 source address with deny and allow tables in RAM.
// A frame byte is taken each cycle while idle with the output free; a short or
// non-IPv4 frame gets its verdict in the cycle after its last beat. Set and
// remove scan the selected table; a lookup scans deny, then allow unless the
// deny hit is flagged. Per entry a RAM read, then a compare; then move, output.
// Reset empties both tables at once through their fill counts; no clearing pass.
module ipv4_source_acl_filter_unit import isaf_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  isaf_in_if.sink    item_i,
  isaf_out_if.source result_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = AW + 1;

  // Entries of each table are packed into addresses 0 .. count-1. A remove
  // moves the last entry into the hole, so the fill count alone says which
  // addresses hold live entries.
  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic            tbl_q, tbl_d;
  logic [31:0]     key_q, key_d;
  logic [7:0]      flag_q, flag_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   deny_cnt_q, deny_cnt_d, allow_cnt_q, allow_cnt_d;
  res_t            res_q, res_d;
  res_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            acc, out_free, byte_beat;
  frm_t            frm;
  logic [CW-1:0]   cur_cnt, tail_idx;
  logic            scan_end, hit, flag_one, is_last;
  entry_t          rdata, deny_rdata, allow_rdata;

  logic            re, deny_we, allow_we;
  logic [AW-1:0]   raddr, waddr;
  entry_t          wdata;

  assign acc       = item_i.valid && item_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;
  assign byte_beat = acc && (item_i.action == ACT_BYTE);
  assign cur_cnt   = tbl_q ? allow_cnt_q : deny_cnt_q;
  assign tail_idx  = cur_cnt - CW'(1);
  assign rdata     = tbl_q ? allow_rdata : deny_rdata;
  assign scan_end  = (idx_q == cur_cnt);
  assign hit       = (rdata.key == key_q);
  assign flag_one  = (rdata.flag == MATCH_FLAG);
  assign is_last   = (idx_q == tail_idx);

  isaf_hdr u_hdr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (byte_beat),
    .data_i (item_i.data_byte),
    .last_i (item_i.last_byte),
    .frm_o  (frm)
  );

  isaf_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_deny_ram (
    .clk_i   (clk_i),
    .we_i    (deny_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (deny_rdata)
  );

  isaf_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_allow_ram (
    .clk_i   (clk_i),
    .we_i    (allow_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (allow_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (item_i.action == ACT_SET || item_i.action == ACT_REMOVE) begin
            state_d = ST_RD;
          end else if (item_i.action == ACT_BYTE && frm.done && frm.lookup) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (!scan_end) begin
          state_d = ST_CMP;
        end else if (op_q == OP_LOOKUP && !tbl_q) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_CMP: begin
        if (!hit) begin
          state_d = ST_RD;
        end else begin
          case (op_q)
            OP_LOOKUP: state_d = (!flag_one && !tbl_q) ? ST_RD : ST_FIN;
            OP_REMOVE: state_d = is_last ? ST_FIN : ST_MV_RD;
            default:   state_d = ST_FIN;
          endcase
        end
      end
      ST_MV_RD: state_d = ST_MV_WR;
      ST_MV_WR: state_d = ST_FIN;
      ST_FIN:   state_d = out_free ? ST_IDLE : ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and outputs.
  always_comb begin
    op_d        = op_q;
    tbl_d       = tbl_q;
    key_d       = key_q;
    flag_d      = flag_q;
    idx_d       = idx_q;
    deny_cnt_d  = deny_cnt_q;
    allow_cnt_d = allow_cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    re          = 1'b0;
    raddr       = idx_q[AW-1:0];
    deny_we     = 1'b0;
    allow_we    = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = '{key: key_q, flag: flag_q};
    item_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        item_i.ready = out_free;
        if (acc) begin
          idx_d  = '0;
          flag_d = item_i.flag_value;
          if (item_i.action == ACT_SET || item_i.action == ACT_REMOVE) begin
            op_d  = (item_i.action == ACT_SET) ? OP_SET : OP_REMOVE;
            tbl_d = item_i.list_select;
            key_d = item_i.address_key;
          end else if (item_i.action == ACT_BYTE && frm.done) begin
            if (frm.lookup) begin
              op_d  = OP_LOOKUP;
              tbl_d = 1'b0;
              key_d = frm.src;
            end else begin
              out_d       = '{kind: KIND_VERDICT, drop: 1'b0, reason: frm.reason,
                              status: STS_DONE, src: '0};
              out_valid_d = 1'b1;
            end
          end
        end
      end
      ST_RD: begin
        res_d = '{kind: KIND_STATUS, drop: 1'b0, reason: RSN_SHORT_MAC,
                  status: STS_DONE, src: '0};
        if (!scan_end) begin
          re = 1'b1;
        end else begin
          case (op_q)
            OP_LOOKUP: begin
              if (!tbl_q) begin
                tbl_d = 1'b1;
                idx_d = '0;
              end else begin
                res_d = '{kind: KIND_VERDICT, drop: 1'b1, reason: RSN_DEFAULT,
                          status: STS_DONE, src: key_q};
              end
            end
            OP_SET: begin
              if (cur_cnt == CW'(TABLE_ENTRIES)) begin
                res_d.status = STS_FULL;
              end else begin
                waddr = cur_cnt[AW-1:0];
                if (tbl_q) begin
                  allow_we    = 1'b1;
                  allow_cnt_d = allow_cnt_q + CW'(1);
                end else begin
                  deny_we    = 1'b1;
                  deny_cnt_d = deny_cnt_q + CW'(1);
                end
              end
            end
            default: res_d.status = STS_NOT_FOUND;
          endcase
        end
      end
      ST_CMP: begin
        res_d = '{kind: KIND_STATUS, drop: 1'b0, reason: RSN_SHORT_MAC,
                  status: STS_DONE, src: '0};
        if (!hit) begin
          idx_d = idx_q + CW'(1);
        end else begin
          case (op_q)
            OP_LOOKUP: begin
              if (flag_one) begin
                res_d = '{kind: KIND_VERDICT, drop: !tbl_q,
                          reason: tbl_q ? RSN_ALLOWED : RSN_DENIED,
                          status: STS_DONE, src: key_q};
              end else if (!tbl_q) begin
                tbl_d = 1'b1;
                idx_d = '0;
              end else begin
                res_d = '{kind: KIND_VERDICT, drop: 1'b1, reason: RSN_DEFAULT,
                          status: STS_DONE, src: key_q};
              end
            end
            OP_SET: begin
              allow_we = tbl_q;
              deny_we  = !tbl_q;
            end
            default: begin
              // Removing the last live entry needs no move.
              if (is_last) begin
                if (tbl_q) begin
                  allow_cnt_d = allow_cnt_q - CW'(1);
                end else begin
                  deny_cnt_d = deny_cnt_q - CW'(1);
                end
              end
            end
          endcase
        end
      end
      ST_MV_RD: begin
        // Fetch the last live entry; it fills the hole left by the remove.
        re    = 1'b1;
        raddr = tail_idx[AW-1:0];
      end
      ST_MV_WR: begin
        wdata = rdata;
        if (tbl_q) begin
          allow_we    = 1'b1;
          allow_cnt_d = allow_cnt_q - CW'(1);
        end else begin
          deny_we    = 1'b1;
          deny_cnt_d = deny_cnt_q - CW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      deny_cnt_q  <= '0;
      allow_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      deny_cnt_q  <= deny_cnt_d;
      allow_cnt_q <= allow_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tbl_q  <= tbl_d;
    key_q  <= key_d;
    flag_q <= flag_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.result_kind    = out_q.kind;
  assign result_o.drop_frame     = out_q.drop;
  assign result_o.verdict_reason = out_q.reason;
  assign result_o.op_status      = out_q.status;
  assign result_o.source_address = out_q.src;

  // Fill counts never pass the table depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deny_cnt_q <= CW'(TABLE_ENTRIES) && allow_cnt_q <= CW'(TABLE_ENTRIES))
    else $error("table fill count above depth");

  // New beats are taken only while no scan is running.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  // A compare always follows a read issued in the cycle before.
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> $past(state_q) == ST_RD)
    else $error("compare without a preceding read");

  // A finished operation leaves a result in the output register.
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_free |=> out_valid_q)
    else $error("finished operation lost its result");

endmodule
